// ===== rtl/cca_pkg.sv =====
package cca_pkg;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [3:0]  DEC_IDX    = 4'd11;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;

  // Division by 60 is (x >> 2) / 15 and division by 24 is (x >> 3) / 3. Both quotients come
  // from (y * M) >> 29, which is exact for every y below 2**25.
  localparam logic [27:0] RCP_FIFTEEN = 28'd35791395;
  localparam logic [27:0] RCP_THREE   = 28'd178956971;
  localparam int unsigned RCP_SHIFT   = 29;

  // Floor of year / 100 for years up to 9999 is (year * 5243) >> 19.
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int unsigned CENT_SHIFT = 19;

  typedef struct packed {
    logic        req_type;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
    logic [25:0] add_seconds;
  } in_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
  } out_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_SEC_Q  = 4'd1;
  localparam step_t STEP_SEC_R  = 4'd2;
  localparam step_t STEP_MIN_Q  = 4'd3;
  localparam step_t STEP_MIN_R  = 4'd4;
  localparam step_t STEP_HOUR_Q = 4'd5;
  localparam step_t STEP_HOUR_R = 4'd6;
  localparam step_t STEP_MON    = 4'd7;
  localparam step_t STEP_OUT    = 4'd8;

  typedef enum logic [2:0] {
    OP_WAIT  = 3'd0,
    OP_QUOT  = 3'd1,
    OP_REM   = 3'd2,
    OP_MONTH = 3'd3,
    OP_EMIT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_SEC  = 2'd1,
    WB_MIN  = 2'd2,
    WB_HOUR = 2'd3
  } wb_t;

  typedef struct packed {
    op_t   op;
    logic  div_day;
    wb_t   wb;
    step_t nxt;
    step_t alt;
  } ucode_t;

  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    case (s)
      STEP_IDLE:   w = '{op: OP_WAIT,  div_day: 1'b0, wb: WB_NONE, nxt: STEP_SEC_Q,
                         alt: STEP_OUT};
      STEP_SEC_Q:  w = '{op: OP_QUOT,  div_day: 1'b0, wb: WB_NONE, nxt: STEP_SEC_R,
                         alt: STEP_SEC_Q};
      STEP_SEC_R:  w = '{op: OP_REM,   div_day: 1'b0, wb: WB_SEC,  nxt: STEP_MIN_Q,
                         alt: STEP_SEC_R};
      STEP_MIN_Q:  w = '{op: OP_QUOT,  div_day: 1'b0, wb: WB_NONE, nxt: STEP_MIN_R,
                         alt: STEP_MIN_Q};
      STEP_MIN_R:  w = '{op: OP_REM,   div_day: 1'b0, wb: WB_MIN,  nxt: STEP_HOUR_Q,
                         alt: STEP_MIN_R};
      STEP_HOUR_Q: w = '{op: OP_QUOT,  div_day: 1'b1, wb: WB_NONE, nxt: STEP_HOUR_R,
                         alt: STEP_HOUR_Q};
      STEP_HOUR_R: w = '{op: OP_REM,   div_day: 1'b1, wb: WB_HOUR, nxt: STEP_MON,
                         alt: STEP_HOUR_R};
      STEP_MON:    w = '{op: OP_MONTH, div_day: 1'b0, wb: WB_NONE, nxt: STEP_OUT,
                         alt: STEP_MON};
      STEP_OUT:    w = '{op: OP_EMIT,  div_day: 1'b0, wb: WB_NONE, nxt: STEP_IDLE,
                         alt: STEP_OUT};
      default:     w = '{op: OP_EMIT,  div_day: 1'b0, wb: WB_NONE, nxt: STEP_IDLE,
                         alt: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Month index is zero based.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/calendar_clock_adder_top.sv =====
// Calendar date and time register with a seconds adder, one transfer out for every transfer in.
// A load transfer sets all six fields (year, month, hour, minute and second saturated into
// range, a zero month or day taken as one) and its result goes straight to the emit step. An
// add transfer runs a small microprogram: three divisions (by 60, 60 and 24), each a
// reciprocal multiplication followed by a remainder step, then a month step that repeats
// while carrying days into following months, and finally the emit step.
// One item is in work at a time; the result sits in an output register, so the next item can
// be taken as soon as its predecessor's result is offered, even while that result waits.
// A finished item whose result register is still full waits in its last step.
module calendar_clock_adder_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cca_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cca_pkg::out_t  out_data
);

  cca_pkg::step_t  step_r, step_nxt;
  cca_pkg::ucode_t uc;

  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [26:0] acc_r, acc_nxt;
  logic [23:0] quot_r, quot_nxt;
  logic [9:0]  days_r, days_nxt;
  logic        leap_r, leap_nxt;
  logic        out_valid_r, out_valid_nxt;
  cca_pkg::out_t out_r, out_nxt;

  logic [24:0] rcp_arg;
  logic [27:0] rcp_mul;
  logic [52:0] rcp_prod;
  logic [26:0] quot_back;
  logic [26:0] rem_full;
  logic [5:0]  rem_new;
  logic [4:0]  cur_len;
  logic [26:0] cent_prod;
  logic [7:0]  cent_q;
  logic [13:0] cent_back;
  logic        in_xfer;

  assign uc        = cca_pkg::ucode(step_r);
  assign in_ready  = (uc.op == cca_pkg::OP_WAIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rcp_arg   = uc.div_day ? {1'b0, acc_r[26:3]} : acc_r[26:2];
  assign rcp_mul   = uc.div_day ? cca_pkg::RCP_THREE : cca_pkg::RCP_FIFTEEN;
  assign rcp_prod  = 53'(rcp_arg) * 53'(rcp_mul);
  assign quot_back = uc.div_day ? (27'({quot_r, 4'b0}) + 27'({quot_r, 3'b0})) :
                                  (27'({quot_r, 6'b0}) - 27'({quot_r, 2'b0}));
  assign rem_full  = acc_r - quot_back;
  assign rem_new   = rem_full[5:0];
  assign cur_len   = cca_pkg::month_len(month_r, leap_r);

  assign cent_prod = 27'(year_r) * 27'(cca_pkg::CENT_RECIP);
  assign cent_q    = cent_prod[cca_pkg::CENT_SHIFT +: 8];
  assign cent_back = 14'({cent_q, 6'b0}) + 14'({cent_q, 5'b0}) + 14'({cent_q, 2'b0});
  assign leap_nxt  = (cent_back == year_r) ? (cent_q[1:0] == 2'd0) : (year_r[1:0] == 2'd0);

  always_comb begin
    step_nxt      = step_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    acc_nxt       = acc_r;
    quot_nxt      = quot_r;
    days_nxt      = days_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (uc.op)
      cca_pkg::OP_WAIT: begin
        if (in_xfer) begin
          if (in_data.req_type == cca_pkg::REQ_ADD) begin
            acc_nxt  = 27'(second_r) + 27'(in_data.add_seconds);
            step_nxt = uc.nxt;
          end else begin
            year_nxt   = (in_data.load_year > cca_pkg::YEAR_MAX) ?
                         cca_pkg::YEAR_MAX : in_data.load_year;
            if (in_data.load_month == 4'd0) begin
              month_nxt = 4'd0;
            end else if (in_data.load_month > cca_pkg::MONTH_MAX) begin
              month_nxt = cca_pkg::DEC_IDX;
            end else begin
              month_nxt = in_data.load_month - 4'd1;
            end
            day_nxt    = (in_data.load_day == 5'd0) ? 5'd1 : in_data.load_day;
            hour_nxt   = (in_data.load_hour > cca_pkg::HOUR_MAX) ?
                         cca_pkg::HOUR_MAX : in_data.load_hour;
            minute_nxt = (in_data.load_minute > cca_pkg::MINSEC_MAX) ?
                         cca_pkg::MINSEC_MAX : in_data.load_minute;
            second_nxt = (in_data.load_second > cca_pkg::MINSEC_MAX) ?
                         cca_pkg::MINSEC_MAX : in_data.load_second;
            step_nxt   = uc.alt;
          end
        end
      end
      cca_pkg::OP_QUOT: begin
        quot_nxt = rcp_prod[cca_pkg::RCP_SHIFT +: 24];
        step_nxt = uc.nxt;
      end
      cca_pkg::OP_REM: begin
        step_nxt = uc.nxt;
        case (uc.wb)
          cca_pkg::WB_SEC: begin
            second_nxt = rem_new;
            acc_nxt    = 27'(minute_r) + 27'(quot_r);
          end
          cca_pkg::WB_MIN: begin
            minute_nxt = rem_new;
            acc_nxt    = 27'(hour_r) + 27'(quot_r);
          end
          cca_pkg::WB_HOUR: begin
            hour_nxt = rem_new[4:0];
            days_nxt = 10'(day_r) + quot_r[9:0];
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
      end
      cca_pkg::OP_MONTH: begin
        if (days_r <= 10'(cur_len)) begin
          day_nxt  = days_r[4:0];
          step_nxt = uc.nxt;
        end else begin
          days_nxt = days_r - 10'(cur_len);
          if (month_r == cca_pkg::DEC_IDX) begin
            month_nxt = 4'd0;
            year_nxt  = (year_r == cca_pkg::YEAR_MAX) ? 14'd0 : year_r + 14'd1;
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      cca_pkg::OP_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.cur_year   = year_r;
          out_nxt.cur_month  = month_r + 4'd1;
          out_nxt.cur_day    = day_r;
          out_nxt.cur_hour   = hour_r;
          out_nxt.cur_minute = minute_r;
          out_nxt.cur_second = second_r;
          out_valid_nxt      = 1'b1;
          step_nxt           = uc.nxt;
        end
      end
      default: begin
        step_nxt = cca_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= cca_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
      year_r      <= cca_pkg::YEAR_RESET;
      month_r     <= 4'd0;
      day_r       <= 5'd1;
      hour_r      <= 5'd0;
      minute_r    <= 6'd0;
      second_r    <= 6'd0;
      leap_r      <= 1'b1;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      leap_r      <= leap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    quot_r <= quot_nxt;
    days_r <= days_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== rtl/cca_checker.sv =====
module cca_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input cca_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input cca_pkg::out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("Input withdrawn or changed while waiting.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed or dropped while stalled.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken while an item is still in work.");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cur_hour <= 5'd23 && out_data.cur_minute <= 6'd59 &&
                  out_data.cur_second <= 6'd59)
    else $error("Time of day out of range.");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cur_month >= 4'd1 && out_data.cur_month <= 4'd12 &&
                  out_data.cur_day >= 5'd1 && out_data.cur_year <= 14'd9999)
    else $error("Date out of range.");

endmodule

bind calendar_clock_adder_top cca_checker u_cca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_calendar_clock_adder_top.sv =====
module tb_calendar_clock_adder_top;

  localparam int RANDOM_ITEMS = 1125;
  localparam int CALM_TAIL    = 150;
  localparam int LONG_HOLD_AT = 260;
  localparam int DRAIN_AT     = 640;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 200;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    cca_pkg::in_t  stim;
    bit            known;
    cca_pkg::out_t want;
  } row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  cca_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  cca_pkg::out_t out_data;

  bit            row_known;
  cca_pkg::out_t row_want;

  cca_pkg::out_t pending_dates[$];
  row_t          plan[$];
  int unsigned   mismatches = 0;
  int unsigned   stall_cycles = 0;
  bit            quiet;
  bit            long_hold_req;

  int unsigned cal_year;
  int unsigned cal_month;
  int unsigned cal_day;
  int unsigned cal_hour;
  int unsigned cal_minute;
  int unsigned cal_second;

  calendar_clock_adder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:              return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic cca_pkg::out_t step_calendar(input cca_pkg::in_t it);
    int unsigned   secs;
    int unsigned   mins;
    int unsigned   hrs;
    int unsigned   days;
    int unsigned   len;
    cca_pkg::out_t r;
    if (it.req_type == cca_pkg::REQ_LOAD) begin
      cal_year   = 32'((it.load_year > cca_pkg::YEAR_MAX) ? cca_pkg::YEAR_MAX : it.load_year);
      cal_month  = (it.load_month == 4'd0) ? 1 :
                   (it.load_month > cca_pkg::MONTH_MAX) ? 32'(cca_pkg::MONTH_MAX) :
                   32'(it.load_month);
      cal_day    = (it.load_day == 5'd0) ? 1 : 32'(it.load_day);
      cal_hour   = 32'((it.load_hour > cca_pkg::HOUR_MAX) ? cca_pkg::HOUR_MAX : it.load_hour);
      cal_minute = 32'((it.load_minute > cca_pkg::MINSEC_MAX) ?
                       cca_pkg::MINSEC_MAX : it.load_minute);
      cal_second = 32'((it.load_second > cca_pkg::MINSEC_MAX) ?
                       cca_pkg::MINSEC_MAX : it.load_second);
    end else begin
      secs       = cal_second + 32'(it.add_seconds);
      mins       = cal_minute + secs / 60;
      cal_second = secs % 60;
      hrs        = cal_hour + mins / 60;
      cal_minute = mins % 60;
      days       = cal_day + hrs / 24;
      cal_hour   = hrs % 24;
      // Excess days walk forward one month at a time, wrapping the year past 9999.
      len = month_days(cal_month, cal_year);
      while (days > len) begin
        days -= len;
        if (cal_month == 12) begin
          cal_month = 1;
          cal_year  = (cal_year == 32'(cca_pkg::YEAR_MAX)) ? 0 : cal_year + 1;
        end else begin
          cal_month++;
        end
        len = month_days(cal_month, cal_year);
      end
      cal_day = days;
    end
    r.cur_year   = 14'(cal_year);
    r.cur_month  = 4'(cal_month);
    r.cur_day    = 5'(cal_day);
    r.cur_hour   = 5'(cal_hour);
    r.cur_minute = 6'(cal_minute);
    r.cur_second = 6'(cal_second);
    return r;
  endfunction

  function automatic cca_pkg::in_t ld(input int y, input int mo, input int d, input int h,
                                      input int mi, input int s);
    cca_pkg::in_t it;
    it.req_type    = cca_pkg::REQ_LOAD;
    it.load_year   = 14'(y);
    it.load_month  = 4'(mo);
    it.load_day    = 5'(d);
    it.load_hour   = 5'(h);
    it.load_minute = 6'(mi);
    it.load_second = 6'(s);
    it.add_seconds = '1;
    return it;
  endfunction

  function automatic cca_pkg::in_t ad(input int unsigned n);
    cca_pkg::in_t it;
    it             = '1;
    it.req_type    = cca_pkg::REQ_ADD;
    it.add_seconds = 26'(n);
    return it;
  endfunction

  function automatic cca_pkg::out_t dt(input int y, input int mo, input int d, input int h,
                                       input int mi, input int s);
    cca_pkg::out_t r;
    r.cur_year   = 14'(y);
    r.cur_month  = 4'(mo);
    r.cur_day    = 5'(d);
    r.cur_hour   = 5'(h);
    r.cur_minute = 6'(mi);
    r.cur_second = 6'(s);
    return r;
  endfunction

  function automatic cca_pkg::in_t random_item();
    cca_pkg::in_t it;
    logic [95:0]  raw;
    int unsigned  pick;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[$bits(cca_pkg::in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.req_type = cca_pkg::REQ_LOAD;
    end else if (pick < 20) begin
      it.req_type = cca_pkg::REQ_LOAD;
      case ($urandom_range(0, 3))
        0:       it.load_year = 14'($urandom_range(0, 9999));
        1:       it.load_year = 14'($urandom_range(9990, 9999));
        2:       it.load_year = 14'($urandom_range(0, 99) * 100 + $urandom_range(0, 1));
        default: it.load_year = 14'($urandom_range(0, 5));
      endcase
      it.load_month  = 4'($urandom_range(1, 12));
      it.load_day    = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                      : $urandom_range(1, 28));
      it.load_hour   = 5'(($urandom_range(0, 2) == 0) ? 23 : $urandom_range(0, 23));
      it.load_minute = 6'(($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59));
      it.load_second = 6'(($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59));
    end else begin
      it.req_type = cca_pkg::REQ_ADD;
      pick        = $urandom_range(0, 99);
      if (pick < 40) begin
        it.add_seconds = 26'($urandom_range(0, 120));
      end else if (pick < 65) begin
        it.add_seconds = 26'($urandom_range(0, 100000));
      end else if (pick < 85) begin
        it.add_seconds = 26'($urandom_range(0, 86400 * 62));
      end else if (pick < 95) begin
        it.add_seconds = 26'($urandom);
      end else begin
        case ($urandom_range(0, 5))
          0:       it.add_seconds = '0;
          1:       it.add_seconds = '1;
          2:       it.add_seconds = 26'd3599;
          3:       it.add_seconds = 26'd3600;
          4:       it.add_seconds = 26'd86399;
          default: it.add_seconds = 26'd86400;
        endcase
      end
    end
    return it;
  endfunction

  task automatic offer(input cca_pkg::in_t it, input bit known, input cca_pkg::out_t want);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_known <= known;
    row_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    cca_pkg::out_t calc;
    cca_pkg::out_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        calc = step_calendar(in_data);
        pending_dates.push_back(row_known ? row_want : calc);
      end
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", out_data.cur_year,
                     out_data.cur_month, out_data.cur_day, out_data.cur_hour,
                     out_data.cur_minute, out_data.cur_second);
          end
        end else begin
          w = pending_dates.pop_front();
          if (out_data.cur_year !== w.cur_year || out_data.cur_month !== w.cur_month ||
              out_data.cur_day !== w.cur_day || out_data.cur_hour !== w.cur_hour ||
              out_data.cur_minute !== w.cur_minute ||
              out_data.cur_second !== w.cur_second) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                       w.cur_year, w.cur_month, w.cur_day, w.cur_hour, w.cur_minute,
                       w.cur_second, out_data.cur_year, out_data.cur_month,
                       out_data.cur_day, out_data.cur_hour, out_data.cur_minute,
                       out_data.cur_second);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL calendar_clock_adder_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // A long hold-off lets the result register and the working item back up.
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    cal_year      = 2000;
    cal_month     = 1;
    cal_day       = 1;
    cal_hour      = 0;
    cal_minute    = 0;
    cal_second    = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    row_known <= 1'b0;
    row_want  <= '0;

    plan.push_back('{ad(0), 1'b1, dt(2000, 1, 1, 0, 0, 0)});
    plan.push_back('{ld(16383, 15, 0, 31, 63, 63), 1'b1, dt(9999, 12, 1, 23, 59, 59)});
    plan.push_back('{ad(1), 1'b1, dt(9999, 12, 2, 0, 0, 0)});
    plan.push_back('{ld(0, 0, 31, 0, 0, 0), 1'b1, dt(0, 1, 31, 0, 0, 0)});
    plan.push_back('{ad(29 * 86400), 1'b1, dt(0, 2, 29, 0, 0, 0)});
    plan.push_back('{ld(2001, 2, 31, 12, 30, 30), 1'b1, dt(2001, 2, 31, 12, 30, 30)});
    plan.push_back('{ad(0), 1'b1, dt(2001, 3, 3, 12, 30, 30)});
    plan.push_back('{ld(1900, 2, 28, 23, 59, 59), 1'b1, dt(1900, 2, 28, 23, 59, 59)});
    plan.push_back('{ad(1), 1'b1, dt(1900, 3, 1, 0, 0, 0)});
    plan.push_back('{ld(2000, 2, 28, 23, 59, 59), 1'b1, dt(2000, 2, 28, 23, 59, 59)});
    plan.push_back('{ad(1), 1'b1, dt(2000, 2, 29, 0, 0, 0)});
    plan.push_back('{ld(2004, 12, 31, 23, 59, 59), 1'b1, dt(2004, 12, 31, 23, 59, 59)});
    plan.push_back('{ad(1), 1'b1, dt(2005, 1, 1, 0, 0, 0)});
    plan.push_back('{ld(2100, 2, 29, 0, 0, 0), 1'b1, dt(2100, 2, 29, 0, 0, 0)});
    plan.push_back('{ad(0), 1'b1, dt(2100, 3, 1, 0, 0, 0)});
    plan.push_back('{ld(9999, 1, 1, 0, 0, 0), 1'b1, dt(9999, 1, 1, 0, 0, 0)});
    plan.push_back('{ad(67108863), 1'b0, '0});
    plan.push_back('{ad(59), 1'b0, '0});
    plan.push_back('{ad(60), 1'b0, '0});
    plan.push_back('{ad(3599), 1'b0, '0});
    plan.push_back('{ad(86400), 1'b0, '0});
    plan.push_back('{ld(2023, 12, 31, 23, 59, 59), 1'b1, dt(2023, 12, 31, 23, 59, 59)});
    plan.push_back('{ad(67108863), 1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].stim, plan[i].known, plan[i].want);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == LONG_HOLD_AT) begin
        long_hold_req = 1'b1;
      end
      if (i == DRAIN_AT) begin
        // The sender stands back until every outstanding result has been seen.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_dates.size() != 0);
      end
      quiet = (i >= RANDOM_ITEMS - CALM_TAIL);
      offer(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("PASS calendar_clock_adder_top");
    end else begin
      $display("FAIL calendar_clock_adder_top");
    end
    $finish;
  end

endmodule
